// ===== src/affect_tag_table_macros.svh =====
// ---------------------------------------------------------------------------
// affect_tag_table assertion macros
// Shared concurrent check forms; expect clk and arst_n in the using module.
// ---------------------------------------------------------------------------
`ifndef AFFECT_TAG_TABLE_MACROS_SVH
`define AFFECT_TAG_TABLE_MACROS_SVH

// same-cycle implication
`define ATT_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ATT_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/att_pkg.sv =====
// ---------------------------------------------------------------------------
// att_pkg
// Types, constants and helpers shared by the affect tag table modules.
// ---------------------------------------------------------------------------
package att_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int MAX_RESULTS = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int ITER_W      = 4;   // 16 steps for divider and root

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	localparam logic signed [15:0] QONE     = 16'sd16384;
	localparam logic signed [15:0] QNEG_ONE = -16'sd16384;
	localparam logic signed [15:0] QZERO    = 16'sd0;

	localparam int S_TDATA_W  = 152;
	localparam int M_TDATA_W  = 208;
	localparam int S_TUSER_W  = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [14:0] THRESHOLD_RST = 15'd4915;
	localparam logic [15:0] GAIN_RST      = 16'd4096;

	typedef enum logic [2:0] {
		CMD_TAG         = 3'd0,
		CMD_CONSOLIDATE = 3'd1,
		CMD_RETRIEVE    = 3'd2,
		CMD_RANGE       = 3'd3,
		CMD_STATS       = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOOST_THRESHOLD = 1'd0,
		REG_RETRIEVAL_GAIN  = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] val;
		logic [14:0] aro;
		logic [63:0] key;
	} row_t;

	// input item, last field in the low bits
	typedef struct packed {
		logic              pad;
		logic [6:0]        max_count;
		logic signed [15:0] range_high;
		logic signed [15:0] range_low;
		logic signed [15:0] intensity_in;
		logic signed [15:0] arousal_in;
		logic signed [15:0] valence_in;
		logic [63:0]       key_id;
	} in_item_t;

	// result item, last field in the low bits
	typedef struct packed {
		logic [31:0]        retrieval_total;
		logic [31:0]        boost_total;
		logic [31:0]        count_out;
		logic [63:0]        id_out;
		logic [14:0]        intensity_out;
		logic [14:0]        arousal_out;
		logic signed [15:0] valence_out;
		logic               has_emotion;
		logic               status;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_SCAN_K, ST_TAG_UPD, ST_TAG_CHK,
		ST_DIV_V, ST_MEAN_V, ST_DIV_A, ST_MEAN_A,
		ST_RET0, ST_RET1, ST_RET2, ST_RET3, ST_RET4, ST_RET5,
		ST_SQRT_INIT, ST_SQRT, ST_RQ1, ST_RQ2, ST_EMIT_ID, ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		DOP_NONE, DOP_LOAD, DOP_SCAN_START, DOP_SCAN_RESTART, DOP_CNT_RESUME,
		DOP_CONS, DOP_TAG_WRITE, DOP_DIV_START_V, DOP_DIV_STEP, DOP_MEAN_V,
		DOP_MEAN_A, DOP_RET0, DOP_RET1, DOP_RET2, DOP_RET3, DOP_RET4, DOP_RET5,
		DOP_SQRT_INIT, DOP_SQRT_STEP, DOP_EMIT_ID, DOP_EMIT_SINGLE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic scan_done;
		logic found;
		logic free_found;
		logic iter_last;
		logic cnt_at_lim;
		logic cnt_zero;
		logic emit_last;
		logic out_busy;
		logic tag_wrap;
	} dp_sts_t;

	function automatic logic signed [15:0] sat16(
		input logic signed [15:0] x,
		input logic signed [15:0] lo,
		input logic signed [15:0] hi
	);
		logic signed [15:0] r;
		r = x;
		if (x < lo) r = lo;
		else if (x > hi) r = hi;
		return r;
	endfunction

endpackage

// ===== src/att_ctrl.sv =====
// ---------------------------------------------------------------------------
// att_ctrl
// Command sequencer: walks each command through scan, update and emit steps.
// ---------------------------------------------------------------------------
`include "affect_tag_table_macros.svh"

module att_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  att_pkg::dp_sts_t sts,
	output att_pkg::dp_cmd_t cmd
);

	att_pkg::state_t state_q, state_d;
	logic            accept;

	assign s_tready = (state_q == att_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= att_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			att_pkg::ST_IDLE: begin
				if (accept) state_d = att_pkg::ST_DECODE;
			end
			att_pkg::ST_DECODE: begin
				case (sts.cmd)
					att_pkg::CMD_TAG, att_pkg::CMD_CONSOLIDATE,
					att_pkg::CMD_RETRIEVE: state_d = att_pkg::ST_SCAN_K;
					att_pkg::CMD_RANGE:    state_d = att_pkg::ST_RQ1;
					att_pkg::CMD_STATS:    state_d = att_pkg::ST_EMIT;
					default:               state_d = att_pkg::ST_IDLE;
				endcase
			end
			att_pkg::ST_SCAN_K: begin
				if (sts.scan_done) begin
					if (sts.cmd == att_pkg::CMD_TAG) state_d = att_pkg::ST_TAG_UPD;
					else if (sts.cmd == att_pkg::CMD_RETRIEVE && sts.found)
						state_d = att_pkg::ST_RET0;
					else state_d = att_pkg::ST_EMIT;
				end
			end
			att_pkg::ST_TAG_UPD: begin
				state_d = (sts.found || sts.free_found) ? att_pkg::ST_TAG_CHK
				                                        : att_pkg::ST_EMIT;
			end
			att_pkg::ST_TAG_CHK: begin
				state_d = sts.tag_wrap ? att_pkg::ST_EMIT : att_pkg::ST_DIV_V;
			end
			att_pkg::ST_DIV_V: begin
				if (sts.iter_last) state_d = att_pkg::ST_MEAN_V;
			end
			att_pkg::ST_MEAN_V: state_d = att_pkg::ST_DIV_A;
			att_pkg::ST_DIV_A: begin
				if (sts.iter_last) state_d = att_pkg::ST_MEAN_A;
			end
			att_pkg::ST_MEAN_A: state_d = att_pkg::ST_EMIT;
			att_pkg::ST_RET0: state_d = att_pkg::ST_RET1;
			att_pkg::ST_RET1: state_d = att_pkg::ST_RET2;
			att_pkg::ST_RET2: state_d = att_pkg::ST_RET3;
			att_pkg::ST_RET3: state_d = att_pkg::ST_RET4;
			att_pkg::ST_RET4: state_d = att_pkg::ST_RET5;
			att_pkg::ST_RET5: state_d = att_pkg::ST_SQRT_INIT;
			att_pkg::ST_SQRT_INIT: state_d = att_pkg::ST_SQRT;
			att_pkg::ST_SQRT: begin
				if (sts.iter_last) state_d = att_pkg::ST_EMIT;
			end
			att_pkg::ST_RQ1: begin
				// first pass only counts matches
				if (sts.scan_done && !(sts.found && !sts.cnt_at_lim)) begin
					state_d = sts.cnt_zero ? att_pkg::ST_EMIT : att_pkg::ST_RQ2;
				end
			end
			att_pkg::ST_RQ2: begin
				if (sts.scan_done) state_d = att_pkg::ST_EMIT_ID;
			end
			att_pkg::ST_EMIT_ID: begin
				if (!sts.out_busy)
					state_d = sts.emit_last ? att_pkg::ST_IDLE : att_pkg::ST_RQ2;
			end
			att_pkg::ST_EMIT: begin
				if (!sts.out_busy) state_d = att_pkg::ST_IDLE;
			end
			default: state_d = att_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = att_pkg::DOP_NONE;
		case (state_q)
			att_pkg::ST_IDLE: begin
				if (accept) cmd.op = att_pkg::DOP_LOAD;
			end
			att_pkg::ST_DECODE: begin
				case (sts.cmd)
					att_pkg::CMD_TAG, att_pkg::CMD_CONSOLIDATE, att_pkg::CMD_RETRIEVE,
					att_pkg::CMD_RANGE: cmd.op = att_pkg::DOP_SCAN_START;
					default:            cmd.op = att_pkg::DOP_NONE;
				endcase
			end
			att_pkg::ST_SCAN_K: begin
				if (sts.scan_done && sts.cmd == att_pkg::CMD_CONSOLIDATE)
					cmd.op = att_pkg::DOP_CONS;
			end
			att_pkg::ST_TAG_UPD: cmd.op = att_pkg::DOP_TAG_WRITE;
			att_pkg::ST_TAG_CHK: begin
				if (!sts.tag_wrap) cmd.op = att_pkg::DOP_DIV_START_V;
			end
			att_pkg::ST_DIV_V, att_pkg::ST_DIV_A: cmd.op = att_pkg::DOP_DIV_STEP;
			att_pkg::ST_MEAN_V:    cmd.op = att_pkg::DOP_MEAN_V;
			att_pkg::ST_MEAN_A:    cmd.op = att_pkg::DOP_MEAN_A;
			att_pkg::ST_RET0:      cmd.op = att_pkg::DOP_RET0;
			att_pkg::ST_RET1:      cmd.op = att_pkg::DOP_RET1;
			att_pkg::ST_RET2:      cmd.op = att_pkg::DOP_RET2;
			att_pkg::ST_RET3:      cmd.op = att_pkg::DOP_RET3;
			att_pkg::ST_RET4:      cmd.op = att_pkg::DOP_RET4;
			att_pkg::ST_RET5:      cmd.op = att_pkg::DOP_RET5;
			att_pkg::ST_SQRT_INIT: cmd.op = att_pkg::DOP_SQRT_INIT;
			att_pkg::ST_SQRT:      cmd.op = att_pkg::DOP_SQRT_STEP;
			att_pkg::ST_RQ1: begin
				if (sts.scan_done) begin
					if (sts.found && !sts.cnt_at_lim) cmd.op = att_pkg::DOP_CNT_RESUME;
					else if (!sts.cnt_zero) cmd.op = att_pkg::DOP_SCAN_RESTART;
				end
			end
			att_pkg::ST_EMIT_ID: begin
				if (!sts.out_busy) cmd.op = att_pkg::DOP_EMIT_ID;
			end
			att_pkg::ST_EMIT: begin
				if (!sts.out_busy) cmd.op = att_pkg::DOP_EMIT_SINGLE;
			end
			default: cmd.op = att_pkg::DOP_NONE;
		endcase
	end

	// second pass revisits only slots counted in the first
	`ATT_CHECK(a_rq2_found, (state_q == att_pkg::ST_RQ2) && sts.scan_done, sts.found, "range pass lost a match")
	`ATT_CHECK(a_emit_id_found, state_q == att_pkg::ST_EMIT_ID, sts.found, "id emit without match")
	`ATT_CHECK(a_tag_after_scan, state_q == att_pkg::ST_TAG_UPD, sts.scan_done, "tag update before scan end")

endmodule

// ===== src/att_dp.sv =====
// ---------------------------------------------------------------------------
// att_dp
// Table memory, slot scanner, divider, root unit, counters and result register.
// ---------------------------------------------------------------------------
`include "affect_tag_table_macros.svh"

module att_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  att_pkg::dp_cmd_t                cmd,
	output att_pkg::dp_sts_t                sts,
	input  logic [att_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [att_pkg::S_TUSER_W-1:0]   s_tuser,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [att_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [att_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [att_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	att_pkg::row_t mem [att_pkg::TABLE_DEPTH];

	att_pkg::in_item_t in_item;
	att_pkg::cmd_t     cmd_q;
	logic [63:0]        key_q;
	logic signed [15:0] v_q, lo_q, hi_q;
	logic [14:0]        a_q, it_q;
	logic [att_pkg::CNT_W-1:0] lim_q, cnt_q, emit_q;

	logic [14:0] thr_q;
	logic [15:0] gain_q;
	logic [att_pkg::TABLE_DEPTH-1:0] used_q;
	logic [31:0] tag_ops_q, boost_q, hits_q;
	logic signed [15:0] mean_v_q;
	logic [14:0] mean_a_q;

	// scanner
	logic                    active_q, issued_all_q, v_s1, done_q, found_q, free_found_q;
	logic [att_pkg::IDX_W-1:0] addr_q, idx_s1, found_idx_q, free_idx_q;
	att_pkg::row_t           row_s1, found_row_q;
	logic                    scanning, issue, s1_used, s1_match;

	// divider and root
	logic [att_pkg::ITER_W-1:0] iter_q;
	logic [32:0] rem_q, rem_sh;
	logic        div_ge, neg_q;
	logic [15:0] dq_q;
	logic signed [17:0] diff, qs, mean_v_nx, mean_a_nx;
	logic [17:0] diff_abs;
	logic [31:0] sx_q;
	logic [18:0] srem_q, srem_sh, strial;
	logic [15:0] sroot_q;
	logic        sq_ge;

	// retrieve arithmetic
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod_q;
	logic signed [34:0] rnd;
	logic signed [15:0] rnd_v, rnd_a;
	logic signed [15:0] ret_v_q;
	logic [14:0]        ret_a_q;
	logic [29:0]        sq_q;

	logic               out_valid_q, out_last_q;
	att_pkg::out_item_t out_q, out_nx;
	logic               out_last_nx, out_load;

	logic signed [15:0] lo_sat, hi_sat;
	logic [6:0]         lim_in;

	assign in_item = att_pkg::in_item_t'(s_tdata);
	assign lo_sat  = att_pkg::sat16(in_item.range_low, att_pkg::QNEG_ONE, att_pkg::QONE);
	assign hi_sat  = att_pkg::sat16(in_item.range_high, att_pkg::QNEG_ONE, att_pkg::QONE);
	assign lim_in  = (in_item.max_count > 7'(att_pkg::MAX_RESULTS))
	               ? 7'(att_pkg::MAX_RESULTS) : in_item.max_count;

	// ---- scan pipeline: one slot issued per cycle, compared in the next cycle
	assign scanning = active_q && !done_q;
	assign issue    = scanning && !issued_all_q;
	assign s1_used  = used_q[idx_s1];
	always_comb begin
		if (cmd_q == att_pkg::CMD_RANGE)
			s1_match = s1_used && ($signed(row_s1.val) >= lo_q)
			                   && ($signed(row_s1.val) <= hi_q);
		else
			s1_match = s1_used && (row_s1.key == key_q);
	end

	always_ff @(posedge clk) begin
		if (issue) row_s1 <= mem[addr_q];
		if (cmd.op == att_pkg::DOP_TAG_WRITE && (found_q || free_found_q))
			mem[found_q ? found_idx_q : free_idx_q] <= '{val: v_q, aro: a_q, key: key_q};
	end

	// ---- divider (restoring, one quotient bit per cycle)
	assign rem_sh = {rem_q[31:0], dq_q[15]};
	assign div_ge = rem_sh >= {1'b0, tag_ops_q};
	assign qs     = neg_q ? -$signed({2'b00, dq_q}) : $signed({2'b00, dq_q});
	assign mean_v_nx = {{2{mean_v_q[15]}}, mean_v_q} + qs;
	assign mean_a_nx = $signed({3'b000, mean_a_q}) + qs;
	always_comb begin
		if (cmd.op == att_pkg::DOP_DIV_START_V)
			diff = {{2{v_q[15]}}, v_q} - {{2{mean_v_q[15]}}, mean_v_q};
		else
			diff = $signed({3'b000, a_q}) - $signed({3'b000, mean_a_q});
		diff_abs = diff[17] ? 18'(-diff) : 18'(diff);
	end

	// ---- integer root, two radicand bits per cycle
	assign srem_sh = {srem_q[16:0], sx_q[31:30]};
	assign strial  = {1'b0, sroot_q, 2'b01};
	assign sq_ge   = srem_sh >= strial;

	// ---- shared multiplier operands
	always_comb begin
		case (cmd.op)
			att_pkg::DOP_RET0: begin
				mul_a = {found_row_q.val[15], found_row_q.val};
				mul_b = {1'b0, gain_q};
			end
			att_pkg::DOP_RET1: begin
				mul_a = {2'b00, found_row_q.aro};
				mul_b = {1'b0, gain_q};
			end
			att_pkg::DOP_RET3: begin
				mul_a = {ret_v_q[15], ret_v_q};
				mul_b = {ret_v_q[15], ret_v_q};
			end
			att_pkg::DOP_RET4: begin
				mul_a = {2'b00, ret_a_q};
				mul_b = {2'b00, ret_a_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round the Q4.12-gain product to nearest (ties up) in Q2.14 then saturate
	always_comb begin
		rnd = ($signed({prod_q[33], prod_q}) + 35'sd2048) >>> 12;
		if (rnd > 35'(att_pkg::QONE)) rnd_v = att_pkg::QONE;
		else if (rnd < 35'(att_pkg::QNEG_ONE)) rnd_v = att_pkg::QNEG_ONE;
		else rnd_v = rnd[15:0];
		if (rnd > 35'(att_pkg::QONE)) rnd_a = att_pkg::QONE;
		else if (rnd < 35'sd0) rnd_a = att_pkg::QZERO;
		else rnd_a = rnd[15:0];
	end

	// ---- result formation
	always_comb begin
		out_nx      = '0;
		out_last_nx = 1'b1;
		out_load    = 1'b0;
		if (cmd.op == att_pkg::DOP_EMIT_ID) begin
			out_load         = 1'b1;
			out_nx.id_out    = found_row_q.key;
			out_nx.count_out = 32'(cnt_q);
			out_last_nx      = (emit_q + 1'b1) == cnt_q;
		end else if (cmd.op == att_pkg::DOP_EMIT_SINGLE) begin
			out_load = 1'b1;
			case (cmd_q)
				att_pkg::CMD_TAG: out_nx.status = !found_q && !free_found_q;
				att_pkg::CMD_CONSOLIDATE: out_nx.has_emotion = found_q;
				att_pkg::CMD_RETRIEVE: begin
					out_nx.has_emotion = found_q;
					if (found_q) begin
						out_nx.valence_out   = ret_v_q;
						out_nx.arousal_out   = ret_a_q;
						out_nx.intensity_out = sroot_q[14:0];
					end
				end
				att_pkg::CMD_STATS: begin
					out_nx.valence_out     = mean_v_q;
					out_nx.arousal_out     = mean_a_q;
					out_nx.count_out       = tag_ops_q;
					out_nx.boost_total     = boost_q;
					out_nx.retrieval_total = hits_q;
				end
				default: out_nx = '0;
			endcase
		end
	end

	// ---- control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= att_pkg::THRESHOLD_RST;
			gain_q       <= att_pkg::GAIN_RST;
			used_q       <= '0;
			tag_ops_q    <= '0;
			boost_q      <= '0;
			hits_q       <= '0;
			mean_v_q     <= '0;
			mean_a_q     <= '0;
			active_q     <= 1'b0;
			issued_all_q <= 1'b0;
			v_s1         <= 1'b0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			addr_q       <= '0;
			cnt_q        <= '0;
			emit_q       <= '0;
			iter_q       <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= att_pkg::CMD_TAG;
		end else begin
			if (cfg_we) begin
				case (att_pkg::cfg_reg_t'(cfg_idx))
					att_pkg::REG_BOOST_THRESHOLD: thr_q  <= cfg_wdata[14:0];
					att_pkg::REG_RETRIEVAL_GAIN:  gain_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;

			// scanner advance
			if (issue) begin
				addr_q <= addr_q + 1'b1;
				if (addr_q == att_pkg::IDX_LAST) issued_all_q <= 1'b1;
			end
			if (scanning) begin
				v_s1 <= issue;
				if (v_s1) begin
					if (s1_match) begin
						found_q <= 1'b1;
						done_q  <= 1'b1;
					end else if (idx_s1 == att_pkg::IDX_LAST) begin
						done_q <= 1'b1;
					end
					if (cmd_q != att_pkg::CMD_RANGE && !s1_used && !free_found_q)
						free_found_q <= 1'b1;
				end
			end

			case (cmd.op)
				att_pkg::DOP_LOAD: cmd_q <= att_pkg::cmd_t'(s_tuser);
				att_pkg::DOP_SCAN_START, att_pkg::DOP_SCAN_RESTART: begin
					active_q     <= 1'b1;
					addr_q       <= '0;
					issued_all_q <= 1'b0;
					v_s1         <= 1'b0;
					done_q       <= 1'b0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					emit_q       <= '0;
					if (cmd.op == att_pkg::DOP_SCAN_START) cnt_q <= '0;
				end
				att_pkg::DOP_CNT_RESUME, att_pkg::DOP_EMIT_ID: begin
					if (cmd.op == att_pkg::DOP_CNT_RESUME) cnt_q <= cnt_q + 1'b1;
					else emit_q <= emit_q + 1'b1;
					// resume after the match just handled
					if (found_idx_q == att_pkg::IDX_LAST) begin
						found_q <= 1'b0;
						done_q  <= 1'b1;
					end else begin
						addr_q       <= found_idx_q + 1'b1;
						issued_all_q <= 1'b0;
						v_s1         <= 1'b0;
						done_q       <= 1'b0;
						found_q      <= 1'b0;
					end
				end
				att_pkg::DOP_CONS: begin
					if (found_q && it_q > thr_q) boost_q <= boost_q + 1'b1;
				end
				att_pkg::DOP_TAG_WRITE: begin
					if (found_q || free_found_q) tag_ops_q <= tag_ops_q + 1'b1;
					if (!found_q && free_found_q) used_q[free_idx_q] <= 1'b1;
				end
				att_pkg::DOP_DIV_START_V, att_pkg::DOP_SQRT_INIT: iter_q <= '0;
				att_pkg::DOP_DIV_STEP, att_pkg::DOP_SQRT_STEP: iter_q <= iter_q + 1'b1;
				att_pkg::DOP_MEAN_V: begin
					mean_v_q <= mean_v_nx[15:0];
					iter_q   <= '0;
				end
				att_pkg::DOP_MEAN_A: mean_a_q <= mean_a_nx[14:0];
				att_pkg::DOP_RET0: hits_q <= hits_q + 1'b1;
				default: ;
			endcase
		end
	end

	// ---- payload registers
	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= addr_q;
		if (scanning && v_s1) begin
			if (s1_match) begin
				found_idx_q <= idx_s1;
				found_row_q <= row_s1;
			end
			if (cmd_q != att_pkg::CMD_RANGE && !s1_used && !free_found_q)
				free_idx_q <= idx_s1;
		end
		if (out_load) begin
			out_q      <= out_nx;
			out_last_q <= out_last_nx;
		end
		case (cmd.op)
			att_pkg::DOP_LOAD: begin
				key_q <= in_item.key_id;
				v_q   <= att_pkg::sat16(in_item.valence_in, att_pkg::QNEG_ONE, att_pkg::QONE);
				a_q   <= att_pkg::sat16(in_item.arousal_in, att_pkg::QZERO, att_pkg::QONE)
				         [14:0];
				it_q  <= att_pkg::sat16(in_item.intensity_in, att_pkg::QZERO, att_pkg::QONE)
				         [14:0];
				lo_q  <= (lo_sat > hi_sat) ? hi_sat : lo_sat;
				hi_q  <= (lo_sat > hi_sat) ? lo_sat : hi_sat;
				lim_q <= att_pkg::CNT_W'(lim_in);
			end
			att_pkg::DOP_DIV_START_V, att_pkg::DOP_MEAN_V: begin
				neg_q <= diff[17];
				dq_q  <= diff_abs[15:0];
				rem_q <= '0;
			end
			att_pkg::DOP_DIV_STEP: begin
				rem_q <= div_ge ? (rem_sh - {1'b0, tag_ops_q}) : rem_sh;
				dq_q  <= {dq_q[14:0], div_ge};
			end
			att_pkg::DOP_RET0: prod_q <= mul_a * mul_b;
			att_pkg::DOP_RET1: begin
				ret_v_q <= rnd_v;
				prod_q  <= mul_a * mul_b;
			end
			att_pkg::DOP_RET2: ret_a_q <= rnd_a[14:0];
			att_pkg::DOP_RET3: prod_q <= mul_a * mul_b;
			att_pkg::DOP_RET4: begin
				sq_q   <= prod_q[29:0];
				prod_q <= mul_a * mul_b;
			end
			att_pkg::DOP_RET5: sq_q <= sq_q + prod_q[29:0];
			att_pkg::DOP_SQRT_INIT: begin
				sx_q    <= {3'b000, sq_q[29:1]};
				srem_q  <= '0;
				sroot_q <= '0;
			end
			att_pkg::DOP_SQRT_STEP: begin
				srem_q  <= sq_ge ? (srem_sh - strial) : srem_sh;
				sroot_q <= {sroot_q[14:0], sq_ge};
				sx_q    <= {sx_q[29:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		sts.cmd        = cmd_q;
		sts.scan_done  = done_q;
		sts.found      = found_q;
		sts.free_found = free_found_q;
		sts.iter_last  = iter_q == {att_pkg::ITER_W{1'b1}};
		sts.cnt_at_lim = cnt_q == lim_q;
		sts.cnt_zero   = cnt_q == '0;
		sts.emit_last  = (emit_q + 1'b1) == cnt_q;
		sts.out_busy   = out_valid_q && !m_tready;
		sts.tag_wrap   = tag_ops_q == '0;
	end

	`ATT_CHECK(a_found_done, found_q, done_q, "match flagged while scan still running")
	`ATT_CHECK(a_emit_le_cnt, 1'b1, emit_q <= cnt_q, "more ids emitted than counted")
	`ATT_CHECK_NEXT(a_fill_marks_used, (cmd.op == att_pkg::DOP_TAG_WRITE) && !found_q && free_found_q, used_q[$past(free_idx_q)], "filled slot not marked used")

endmodule

// ===== src/affect_tag_table.sv =====
// ---------------------------------------------------------------------------
// affect_tag_table
// Keyed table of Q2.14 valence/arousal tags with tag, consolidate, retrieve,
// valence range query and statistics commands.
// ---------------------------------------------------------------------------
// One command is worked at a time; the next is taken once the previous one
// has placed its last result in the output register. The table is a single
// port memory searched one slot per cycle, so a key lookup ends early on a
// hit. A tag then adds two mean divisions; retrieve adds six multiply steps
// and an integer root. A range query scans twice, first to count matches and
// then to emit them, and output stalls can hold it. No clearing pass follows
// reset.
module affect_tag_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key_id, valence_in, arousal_in, intensity_in, range_low, range_high,
	// max_count, zero pad
	input  logic [att_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd
	input  logic [att_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status, has_emotion, valence_out, arousal_out, intensity_out, id_out,
	// count_out, boost_total, retrieval_total
	output logic [att_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [att_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [att_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	att_pkg::dp_cmd_t dp_cmd;
	att_pkg::dp_sts_t dp_sts;

	att_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	att_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// ===== dv/affect_tag_table_test.sv =====
// ---------------------------------------------------------------------------
// affect_tag_table_test
// Self-checking bench for the affect tag table. It drives commands on the
// slave stream and writes registers on the config port while the block is
// idle. A scoreboard class predicts every result transfer and compares it
// field by field. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module affect_tag_table_test;
	import att_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 700;
	localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;

	typedef struct {
		out_item_t res;
		bit        lst;
	} affect_result_t;

	class affect_scoreboard;
		int unsigned    threshold;
		int unsigned    gain;
		bit [63:0]      slot_key[TABLE_DEPTH];
		int             slot_val[TABLE_DEPTH];
		int             slot_aro[TABLE_DEPTH];
		bit             slot_used[TABLE_DEPTH];
		int unsigned    tag_ops, boosts, hits;
		int             mean_val, mean_aro;
		affect_result_t pending[$];
		int             mismatches;
		int             results_seen;
		int             cmd_seen[8];

		function new();
			threshold = THRESHOLD_RST;
			gain      = GAIN_RST;
			foreach (slot_used[i]) slot_used[i] = 0;
			tag_ops = 0; boosts = 0; hits = 0;
			mean_val = 0; mean_aro = 0;
			mismatches = 0; results_seen = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] data);
			if (idx == REG_BOOST_THRESHOLD) threshold = data & 16'h7fff;
			else gain = data;
		endfunction

		function int clampi(int x, int lo, int hi);
			return x < lo ? lo : (x > hi ? hi : x);
		endfunction

		function int lookup(bit [63:0] k);
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (slot_used[i] && slot_key[i] == k) return i;
			return -1;
		endfunction

		function int scaled(int v);
			longint p;
			p = longint'(v) * longint'(gain) + 2048;
			return int'(p >>> 12);
		endfunction

		function int unsigned root(int unsigned x);
			int unsigned r, b;
			r = 0;
			b = 32'h4000_0000;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_input(logic [2:0] cmd, in_item_t it);
			affect_result_t e;
			int idx, v, a, lo, hi, t, lim;
			bit [63:0] hits_q[$];
			cmd_seen[cmd]++;
			if (cmd >= CMD_FIRST_UNUSED) return;
			e.res = '0;
			e.lst = 1;
			case (cmd)
				CMD_TAG: begin
					v = clampi(int'(it.valence_in), -16384, 16384);
					a = clampi(int'(it.arousal_in), 0, 16384);
					idx = lookup(it.key_id);
					if (idx < 0) begin
						for (int i = 0; i < TABLE_DEPTH; i++)
							if (!slot_used[i]) begin
								idx = i;
								break;
							end
						if (idx >= 0) begin
							slot_used[idx] = 1;
							slot_key[idx] = it.key_id;
						end
					end
					if (idx < 0) begin
						e.res.status = 1;
					end else begin
						slot_val[idx] = v;
						slot_aro[idx] = a;
						tag_ops++;
						if (tag_ops != 0) begin
							mean_val += int'((longint'(v) - mean_val) / longint'(tag_ops));
							mean_aro += int'((longint'(a) - mean_aro) / longint'(tag_ops));
						end
					end
				end
				CMD_CONSOLIDATE: begin
					t = clampi(int'(it.intensity_in), 0, 16384);
					if (lookup(it.key_id) >= 0) begin
						e.res.has_emotion = 1;
						if (t > threshold) boosts++;
					end
				end
				CMD_RETRIEVE: begin
					idx = lookup(it.key_id);
					if (idx >= 0) begin
						v = clampi(scaled(slot_val[idx]), -16384, 16384);
						a = clampi(scaled(slot_aro[idx]), 0, 16384);
						e.res.has_emotion   = 1;
						e.res.valence_out   = v[15:0];
						e.res.arousal_out   = a[14:0];
						e.res.intensity_out = 15'(root((v * v + a * a) >> 1));
						hits++;
					end
				end
				CMD_RANGE: begin
					lo = clampi(int'(it.range_low), -16384, 16384);
					hi = clampi(int'(it.range_high), -16384, 16384);
					if (lo > hi) begin
						t = lo; lo = hi; hi = t;
					end
					lim = it.max_count > MAX_RESULTS ? MAX_RESULTS : it.max_count;
					for (int i = 0; i < TABLE_DEPTH && hits_q.size() < lim; i++)
						if (slot_used[i] && slot_val[i] >= lo && slot_val[i] <= hi)
							hits_q.push_back(slot_key[i]);
					foreach (hits_q[k]) begin
						e.res.id_out    = hits_q[k];
						e.res.count_out = hits_q.size();
						e.lst = (k == hits_q.size() - 1);
						pending.push_back(e);
					end
					if (hits_q.size() != 0) return;
				end
				default: begin
					e.res.valence_out     = mean_val[15:0];
					e.res.arousal_out     = mean_aro[14:0];
					e.res.count_out       = tag_ops;
					e.res.boost_total     = boosts;
					e.res.retrieval_total = hits;
				end
			endcase
			pending.push_back(e);
		endfunction

		function void field_check(string name, logic [63:0] exp_v, logic [63:0] got_v);
			if (exp_v !== got_v) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d, %s: expected %0h, got %0h",
						results_seen, name, exp_v, got_v);
			end
		endfunction

		function void check_result(out_item_t got, logic got_last);
			affect_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected", results_seen);
				return;
			end
			e = pending.pop_front();
			field_check("status", e.res.status, got.status);
			field_check("has_emotion", e.res.has_emotion, got.has_emotion);
			field_check("valence_out", e.res.valence_out, got.valence_out);
			field_check("arousal_out", e.res.arousal_out, got.arousal_out);
			field_check("intensity_out", e.res.intensity_out, got.intensity_out);
			field_check("id_out", e.res.id_out, got.id_out);
			field_check("count_out", e.res.count_out, got.count_out);
			field_check("boost_total", e.res.boost_total, got.boost_total);
			field_check("retrieval_total", e.res.retrieval_total, got.retrieval_total);
			field_check("tlast", e.lst, got_last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	affect_scoreboard sb;
	int               stall_left;
	bit               smooth_flow;   // no idling on either side while set
	int               idle_cycles;
	int               items_sent;
	bit [63:0]        key_pool[24];

	affect_tag_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (smooth_flow) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls, check every transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready)
				sb.check_result(out_item_t'(m_tdata), m_tlast);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send(logic [2:0] cmd, in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= it;
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(cmd, it);
		items_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		cfg_we    <= 1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, data);
	endtask

	function automatic logic [15:0] pick_q();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(-16384 + $urandom_range(0, 2) - 1);
			3: return 16'(16383 + $urandom_range(0, 2));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.pad          = 0;
		it.key_id       = $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, 23)];
		it.valence_in   = pick_q();
		it.arousal_in   = pick_q();
		it.intensity_in = pick_q();
		it.range_low    = pick_q();
		it.range_high   = pick_q();
		it.max_count    = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(1, 8));
		return it;
	endfunction

	function automatic logic [2:0] random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return CMD_TAG;
		if (r < 50) return CMD_CONSOLIDATE;
		if (r < 72) return CMD_RETRIEVE;
		if (r < 87) return CMD_RANGE;
		if (r < 96) return CMD_STATS;
		return 3'($urandom_range(CMD_FIRST_UNUSED, 7));
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) smooth_flow = ($urandom_range(0, 3) == 0);
			send(random_cmd(), random_item());
		end
		smooth_flow = 0;
	endtask

	initial begin
		in_item_t it;
		sb = new();
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0; s_tuser = '0;
		cfg_we = 0; cfg_idx = REG_BOOST_THRESHOLD; cfg_wdata = '0;
		smooth_flow = 0; idle_cycles = 0; items_sent = 0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, update of a known key, hits and misses
		it = '0;
		it.key_id = '1; it.valence_in = 16'sh7fff; it.arousal_in = 16'sh7fff;
		send(CMD_TAG, it);
		it.key_id = '0; it.valence_in = 16'sh8000; it.arousal_in = 16'sh8000;
		send(CMD_TAG, it);
		it.key_id = 64'h1234; it.valence_in = 16'sd8000; it.arousal_in = 16'sd12000;
		send(CMD_TAG, it);
		it.valence_in = -16'sd9000; it.arousal_in = 16'sd300;
		send(CMD_TAG, it);
		it.intensity_in = 16'sd4916;
		send(CMD_CONSOLIDATE, it);
		it.intensity_in = 16'sd4915;
		send(CMD_CONSOLIDATE, it);
		it.intensity_in = 16'sh7fff; it.key_id = 64'h5555;
		send(CMD_CONSOLIDATE, it);
		send(CMD_RETRIEVE, it);
		foreach (key_pool[i]) if (i < 2) begin
			it.key_id = key_pool[i];
			send(CMD_RETRIEVE, it);
		end
		it.key_id = 64'h1234;
		send(CMD_RETRIEVE, it);
		it.range_low = 16'sh7fff; it.range_high = 16'sh8000; it.max_count = 7'd127;
		send(CMD_RANGE, it);
		it.max_count = 0;
		send(CMD_RANGE, it);
		it.range_low = 16'sd100; it.range_high = 16'sd200; it.max_count = 7'd1;
		send(CMD_RANGE, it);
		it.range_low = -16'sd9000; it.range_high = -16'sd9000;
		send(CMD_RANGE, it);
		for (int c = CMD_FIRST_UNUSED; c <= 7; c++) send(3'(c), it);
		send(CMD_STATS, it);
		settle();

		// random traffic under several register settings, extremes included
		write_reg(REG_BOOST_THRESHOLD, 16'd0);
		write_reg(REG_RETRIEVAL_GAIN, 16'd0);
		random_phase(35);
		settle();
		write_reg(REG_BOOST_THRESHOLD, 16'hc000);   // top bit dropped by the register
		write_reg(REG_RETRIEVAL_GAIN, 16'hffff);
		random_phase(40);
		settle();
		write_reg(REG_BOOST_THRESHOLD, 16'($urandom_range(0, 16384)));
		write_reg(REG_RETRIEVAL_GAIN, 16'($urandom));
		random_phase(40);
		settle();
		write_reg(REG_BOOST_THRESHOLD, 16'd16384);
		write_reg(REG_RETRIEVAL_GAIN, 16'd4096);
		random_phase(35);

		// fill the table with fresh keys, past the point where tags come back full
		for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
			it = random_item();
			it.key_id = {32'hfeed_0000 | i, $urandom};
			send(CMD_TAG, it);
		end
		for (int i = 0; i < 6; i++) begin
			it = random_item();
			it.range_low = 16'sh8000; it.range_high = 16'sh7fff;
			it.max_count = i < 3 ? 7'd64 : 7'($urandom_range(65, 127));
			send(i % 2 ? CMD_RANGE : CMD_RETRIEVE, it);
			send(CMD_RANGE, it);
		end
		random_phase(20);
		send(CMD_STATS, it);
		settle();

		$display("%0d commands sent (%0d tag, %0d range, %0d ignored), %0d results checked",
			items_sent, sb.cmd_seen[CMD_TAG], sb.cmd_seen[CMD_RANGE],
			items_sent - sb.cmd_seen[CMD_TAG] - sb.cmd_seen[CMD_CONSOLIDATE]
			- sb.cmd_seen[CMD_RETRIEVE] - sb.cmd_seen[CMD_RANGE] - sb.cmd_seen[CMD_STATS],
			sb.results_seen);
		$display("register settings: reset, both zero, both maximal, random; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
